>>> hw/rtl/sme_pkg.sv
// Shared opcodes, status codes and widths for the stack machine executor.
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

  localparam int unsigned DataW             = 32;
  localparam int unsigned OpW               = 3;
  localparam int unsigned StatW             = 3;
  localparam int unsigned OutUserW          = 1 + StatW + 1;
  localparam int unsigned StackDepthDefault = 256;

  typedef enum logic [OpW-1:0] {
    OP_NOP  = 3'd0,
    OP_PUSH = 3'd1,
    OP_OUT  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_MUL  = 3'd5,
    OP_DIV  = 3'd6,
    OP_HALT = 3'd7
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 3'd0,
    STAT_UNDER = 3'd1,
    STAT_OVER  = 3'd2,
    STAT_DIVZ  = 3'd3,
    STAT_HALT  = 3'd4
  } status_e;

endpackage

`default_nettype wire

>>> hw/rtl/stack_machine_executor_unit.sv
// Stack machine executor: one instruction per request, stack held in a single-port RAM.
// Push, nop, halt, underflow and overflow answer straight from idle; out reads the top entry,
// then answers; add, sub, mul and divide by zero read both operands first, and div then runs
// a restoring division (one quotient bit a cycle, 32 steps). One instruction at a time; the
// single RAM port serialises the two operand reads and the write-back of each instruction.
// Reset (async, active low) empties the stack and clears the halt flag; RAM contents
// are not cleared and entries are only read after a push has written them.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_executor_unit #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sme_pkg::DataW-1:0]     s_axis_tdata,   // [31:0] push_value
  input  wire logic [sme_pkg::OpW-1:0]       s_axis_tuser,   // [2:0] func
  // result channel
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sme_pkg::DataW-1:0]          m_axis_tdata,   // [31:0] out_value
  output logic [sme_pkg::OutUserW-1:0]       m_axis_tuser    // [0] out_valid, [3:1] status,
                                                             // [4] halted
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW    = sme_pkg::DataW;
  localparam int unsigned BitW  = $clog2(DW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_LEFT,
    ST_DIV,
    ST_FIN
  } state_e;

  // ---------------------------------------------------------------- stack RAM
  logic [DW-1:0]    stack_mem_q [STACK_DEPTH];
  logic [DW-1:0]    mem_rdata_q;
  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [DW-1:0]    mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= stack_mem_q[mem_addr];
    end
  end

  // ---------------------------------------------------------------- control
  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               halt_q, halt_d;
  sme_pkg::op_e       op_q, op_d;
  logic [DW-1:0]      r_q, r_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [DW-1:0]      quo_q, quo_d;
  logic [DW-1:0]      mb_q, mb_d;
  logic               neg_q, neg_d;
  logic [BitW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DW-1:0]      pend_value_q, pend_value_d;
  logic               pend_valid_q, pend_valid_d;
  sme_pkg::status_e   pend_status_q, pend_status_d;
  logic               m_tvalid_q, m_tvalid_d;
  logic [DW-1:0]      m_tdata_q, m_tdata_d;
  logic [sme_pkg::OutUserW-1:0] m_tuser_q, m_tuser_d;

  logic               can_load;
  logic               accept;
  sme_pkg::op_e       in_op;
  logic [CntW-1:0]    cnt_m1;
  logic [CntW-1:0]    cnt_m2;
  logic               ld_out;
  logic [DW-1:0]      ld_value;
  logic               ld_valid;
  sme_pkg::status_e   ld_status;
  logic [DW-1:0]      left;
  logic [DW:0]        rem_sh;
  logic [DW:0]        rem_diff;
  logic [DW-1:0]      quo_next;

  assign can_load      = !m_tvalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && can_load;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = sme_pkg::op_e'(s_axis_tuser);
  assign cnt_m1        = count_q - CntW'(1);
  assign cnt_m2        = count_q - CntW'(2);
  assign left          = mem_rdata_q;

  // one restoring division step
  assign rem_sh   = {rem_q, quo_q[DW-1]};
  assign rem_diff = rem_sh - {1'b0, mb_q};
  assign quo_next = {quo_q[DW-2:0], !rem_diff[DW]};

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    halt_d        = halt_q;
    op_d          = op_q;
    r_d           = r_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    mb_d          = mb_q;
    neg_d         = neg_q;
    bit_cnt_d     = bit_cnt_q;
    pend_value_d  = pend_value_q;
    pend_valid_d  = pend_valid_q;
    pend_status_d = pend_status_q;
    m_tvalid_d    = m_tvalid_q && !m_axis_tready;
    m_tdata_d     = m_tdata_q;
    m_tuser_d     = m_tuser_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = cnt_m1[AddrW-1:0];
    mem_wdata     = s_axis_tdata;
    ld_out        = 1'b0;
    ld_value      = '0;
    ld_valid      = 1'b0;
    ld_status     = sme_pkg::STAT_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = in_op;
          if (halt_q) begin
            ld_out    = 1'b1;
            ld_status = sme_pkg::STAT_HALT;
          end else begin
            case (in_op)
              sme_pkg::OP_HALT: begin
                halt_d    = 1'b1;
                ld_out    = 1'b1;
                ld_status = sme_pkg::STAT_HALT;
              end
              sme_pkg::OP_PUSH: begin
                ld_out = 1'b1;
                if (count_q == CntW'(STACK_DEPTH)) begin
                  ld_status = sme_pkg::STAT_OVER;
                end else begin
                  mem_we   = 1'b1;
                  mem_addr = count_q[AddrW-1:0];
                  count_d  = count_q + CntW'(1);
                end
              end
              sme_pkg::OP_OUT: begin
                if (count_q == '0) begin
                  ld_out    = 1'b1;
                  ld_status = sme_pkg::STAT_UNDER;
                end else begin
                  mem_re  = 1'b1;
                  state_d = ST_RD_TOP;
                end
              end
              sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
                if (count_q < CntW'(2)) begin
                  ld_out    = 1'b1;
                  ld_status = sme_pkg::STAT_UNDER;
                end else begin
                  mem_re  = 1'b1;
                  state_d = ST_RD_TOP;
                end
              end
              default: begin
                ld_out = 1'b1;
              end
            endcase
          end
        end
      end

      ST_RD_TOP: begin
        r_d = mem_rdata_q;
        if (op_q == sme_pkg::OP_OUT) begin
          count_d       = cnt_m1;
          pend_value_d  = mem_rdata_q;
          pend_valid_d  = 1'b1;
          pend_status_d = sme_pkg::STAT_OK;
          state_d       = ST_FIN;
        end else begin
          mem_re   = 1'b1;
          mem_addr = cnt_m2[AddrW-1:0];
          state_d  = ST_RD_LEFT;
        end
      end

      ST_RD_LEFT: begin
        pend_value_d  = '0;
        pend_valid_d  = 1'b0;
        pend_status_d = sme_pkg::STAT_OK;
        mem_addr      = cnt_m2[AddrW-1:0];
        case (op_q)
          sme_pkg::OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = left + r_q;
            count_d   = cnt_m1;
            state_d   = ST_FIN;
          end
          sme_pkg::OP_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = left - r_q;
            count_d   = cnt_m1;
            state_d   = ST_FIN;
          end
          sme_pkg::OP_MUL: begin
            mem_we    = 1'b1;
            mem_wdata = left * r_q;
            count_d   = cnt_m1;
            state_d   = ST_FIN;
          end
          default: begin
            if (r_q == '0) begin
              pend_status_d = sme_pkg::STAT_DIVZ;
              state_d       = ST_FIN;
            end else begin
              // divide magnitudes, fix the sign at the end
              neg_d     = left[DW-1] ^ r_q[DW-1];
              quo_d     = left[DW-1] ? (DW'(0) - left) : left;
              mb_d      = r_q[DW-1] ? (DW'(0) - r_q) : r_q;
              rem_d     = '0;
              bit_cnt_d = '0;
              state_d   = ST_DIV;
            end
          end
        endcase
      end

      ST_DIV: begin
        rem_d     = rem_diff[DW] ? rem_sh[DW-1:0] : rem_diff[DW-1:0];
        quo_d     = quo_next;
        bit_cnt_d = bit_cnt_q + BitW'(1);
        mem_addr  = cnt_m2[AddrW-1:0];
        if (bit_cnt_q == BitW'(DW - 1)) begin
          mem_we    = 1'b1;
          mem_wdata = neg_q ? (DW'(0) - quo_next) : quo_next;
          count_d   = cnt_m1;
          state_d   = ST_FIN;
        end
      end

      ST_FIN: begin
        if (can_load) begin
          ld_out    = 1'b1;
          ld_value  = pend_value_q;
          ld_valid  = pend_valid_q;
          ld_status = pend_status_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ld_out) begin
      m_tvalid_d = 1'b1;
      m_tdata_d  = ld_value;
      m_tuser_d  = {halt_d, ld_status, ld_valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      halt_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      halt_q     <= halt_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    r_q           <= r_d;
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    mb_q          <= mb_d;
    neg_q         <= neg_d;
    bit_cnt_q     <= bit_cnt_d;
    pend_value_q  <= pend_value_d;
    pend_valid_q  <= pend_valid_d;
    pend_status_q <= pend_status_d;
    m_tdata_q     <= m_tdata_d;
    m_tuser_q     <= m_tuser_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("request taken while busy");

  a_halted_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[sme_pkg::OutUserW-1]) |->
      (m_axis_tuser[sme_pkg::StatW:1] == sme_pkg::STAT_HALT))
    else $error("halted result without halt status");
`endif

endmodule

`default_nettype wire
